// ----- design/touch_scan_hysteresis_detector_defines.svh -----
// Assertion macros for the touch scan hysteresis detector.
`ifndef TOUCH_SCAN_HYSTERESIS_DETECTOR_DEFINES_SVH
`define TOUCH_SCAN_HYSTERESIS_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSHD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tshd_pkg.sv -----
// Shared types and constants of the touch scan hysteresis detector.
package tshd_pkg;

	localparam int CHANNELS_DEF = 6;
	localparam int SAMPLE_W     = 16;
	localparam int LEVEL_W      = 12;
	localparam int GAP_W        = 16;
	localparam int SCAN_W       = 5;
	localparam int CHAN_OUT_W   = 3;
	localparam int MASK_W       = 6;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;
	localparam int SHIFT        = 4;

	localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd100;
	localparam logic [LEVEL_W-1:0] PRESS_RESET = 12'd200;
	localparam logic [LEVEL_W-1:0] DROP_RESET  = 12'd120;
	localparam logic [LEVEL_W-1:0] BASE_RESET  = '1;

	localparam logic [1:0] REG_GAP   = 2'd0;
	localparam logic [1:0] REG_PRESS = 2'd1;
	localparam logic [1:0] REG_DROP  = 2'd2;

	typedef struct packed {
		logic [GAP_W-1:0]   gap_ticks;
		logic [LEVEL_W-1:0] press_level;
		logic [LEVEL_W-1:0] release_drop;
	} cfg_t;

	typedef struct packed {
		logic                conv_done;
		logic                conv_valid;
		logic [SAMPLE_W-1:0] conv_sample;
	} item_t;

	typedef struct packed {
		logic                  start_conv;
		logic [CHAN_OUT_W-1:0] conv_channel;
		logic                  change_irq;
		logic [MASK_W-1:0]     pressed_mask;
		logic [LEVEL_W-1:0]    touch_level;
	} result_t;

endpackage

// ----- design/touch_scan_hysteresis_detector.sv -----
// Top level of the touch scan hysteresis detector.
// Each accepted item is one tick of converter status and yields exactly one result item.
// The block takes a new item every cycle when the result side keeps up: an input register
// feeds the scan sequencer and channel state, whose next result is loaded into an output
// register when the held item advances. While the output register is stalled, one more
// item is held in the input register before item_stall rises. Sustained rate is one item
// per clock when not stalled, set by the update of the selected channel's baseline and flag.
`include "touch_scan_hysteresis_detector_defines.svh"

module touch_scan_hysteresis_detector #(
	parameter int CHANNELS = tshd_pkg::CHANNELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tshd_pkg::ADDR_W-1:0]     paddr,
	input  logic [tshd_pkg::DATA_W-1:0]     pwdata,
	output logic [tshd_pkg::DATA_W-1:0]     prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic                            conv_done,
	input  logic                            conv_valid,
	input  logic [tshd_pkg::SAMPLE_W-1:0]   conv_sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic                            start_conv,
	output logic [tshd_pkg::CHAN_OUT_W-1:0] conv_channel,
	output logic                            change_irq,
	output logic [tshd_pkg::MASK_W-1:0]     pressed_mask,
	output logic [tshd_pkg::LEVEL_W-1:0]    touch_level
);
	import tshd_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;
	logic    adv, load_s1;

	tshd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tshd_core #(.CHANNELS(CHANNELS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.item   (item_s1),
		.adv    (adv),
		.result (res_next)
	);

	assign adv        = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !adv;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1.conv_done   <= conv_done;
			item_s1.conv_valid  <= conv_valid;
			item_s1.conv_sample <= conv_sample;
		end
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign start_conv   = res_s2.start_conv;
	assign conv_channel = res_s2.conv_channel;
	assign change_irq   = res_s2.change_irq;
	assign pressed_mask = res_s2.pressed_mask;
	assign touch_level  = res_s2.touch_level;

	`TSHD_ASSERT_IMPL(a_stall_needs_item, item_stall, valid_s1, "stall without held item")
	`TSHD_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(item_s1), "held item lost")
	`TSHD_ASSERT_NEXT(a_adv_fills_out, adv, valid_s2, "advanced item not in output register")
	`TSHD_ASSERT_IMPL(a_start_no_irq, valid_s2 && res_s2.start_conv, !res_s2.change_irq, "start with change")

endmodule

// ----- design/tshd_regs.sv -----
// Configuration register file with APB-style access.
module tshd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tshd_pkg::ADDR_W-1:0]   paddr,
	input  logic [tshd_pkg::DATA_W-1:0]   pwdata,
	output logic [tshd_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output tshd_pkg::cfg_t                cfg
);
	import tshd_pkg::*;

	logic       wr_en;
	logic [1:0] reg_idx;
	cfg_t       cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_ticks    <= GAP_RESET;
			cfg_q.press_level  <= PRESS_RESET;
			cfg_q.release_drop <= DROP_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GAP:   cfg_q.gap_ticks    <= pwdata[GAP_W-1:0];
				REG_PRESS: cfg_q.press_level  <= pwdata[LEVEL_W-1:0];
				REG_DROP:  cfg_q.release_drop <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAP:   prdata = DATA_W'(cfg_q.gap_ticks);
			REG_PRESS: prdata = DATA_W'(cfg_q.press_level);
			REG_DROP:  prdata = DATA_W'(cfg_q.release_drop);
			default:   prdata = '0;
		endcase
	end

endmodule

// ----- design/tshd_core.sv -----
// Scan sequencer, per-channel baseline and pressed state, and the next result.
module tshd_core #(
	parameter int CHANNELS = tshd_pkg::CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tshd_pkg::cfg_t    cfg,
	input  tshd_pkg::item_t   item,
	input  logic              adv,
	output tshd_pkg::result_t result
);
	import tshd_pkg::*;

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [SCAN_W-1:0] SCAN_LAST  = SCAN_W'(CHANNELS);
	localparam logic [SCAN_W-1:0] SCAN_BEFORE = '1;

	localparam logic [1:0] PHASE_GAP  = 2'd0;
	localparam logic [1:0] PHASE_PICK = 2'd1;
	localparam logic [1:0] PHASE_WAIT = 2'd2;

	logic [1:0]         phase_q, phase_d;
	logic [GAP_W-1:0]   gap_count_q, gap_count_d;
	logic [SCAN_W-1:0]  scan_q, scan_d, scan_inc;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [LEVEL_W-1:0] base_q [CHANNELS];
	logic [CHANNELS-1:0] flag_q, flag_n;
	logic [LEVEL_W-1:0] base_n [CHANNELS];

	logic [IDX_W-1:0]   ch;
	logic [LEVEL_W-1:0] val, base_rd, base_new, lvl;
	logic               flag_rd, now, upd, start;
	logic signed [LEVEL_W+1:0] thr, lvl_s;
	logic [MASK_W-1:0]  mask;

	assign scan_inc = scan_q + 1'b1;
	assign ch       = scan_q[IDX_W-1:0];
	assign val      = item.conv_sample[SAMPLE_W-1:SHIFT];
	assign base_rd  = base_q[ch];
	assign flag_rd  = flag_q[ch];
	assign base_new = (val < base_rd) ? val : base_rd;
	assign lvl      = val - base_new;
	assign lvl_s    = $signed({2'b00, lvl});
	assign thr      = $signed({2'b00, cfg.press_level})
		- (flag_rd ? $signed({2'b00, cfg.release_drop}) : $signed((LEVEL_W+2)'(0)));
	assign now      = lvl_s > thr;

	always_comb begin
		phase_d     = phase_q;
		gap_count_d = gap_count_q;
		scan_d      = scan_q;
		level_d     = level_q;
		start       = 1'b0;
		upd         = 1'b0;
		case (phase_q)
			PHASE_GAP: begin
				if (gap_count_q == '0) begin
					phase_d = PHASE_PICK;
					scan_d  = SCAN_BEFORE;
				end else begin
					gap_count_d = gap_count_q - 1'b1;
				end
			end
			PHASE_PICK: begin
				scan_d = scan_inc;
				if (scan_inc >= SCAN_LAST) begin
					gap_count_d = cfg.gap_ticks;
					phase_d     = PHASE_GAP;
				end else begin
					phase_d = PHASE_WAIT;
					start   = 1'b1;
				end
			end
			PHASE_WAIT: begin
				if (item.conv_done) begin
					phase_d = PHASE_PICK;
					upd     = item.conv_valid && (scan_q < SCAN_LAST);
					if (upd) begin
						level_d = lvl;
					end
				end
			end
			default: phase_d = PHASE_GAP;
		endcase
	end

	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			if (upd && scan_q == SCAN_W'(i)) begin
				flag_n[i] = now;
				base_n[i] = base_new;
			end else begin
				flag_n[i] = flag_q[i];
				base_n[i] = base_q[i];
			end
		end
	end

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_on
			assign mask[g] = flag_n[g];
		end else begin : g_off
			assign mask[g] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PHASE_GAP;
			gap_count_q <= GAP_RESET;
			scan_q      <= SCAN_BEFORE;
			level_q     <= '0;
			flag_q      <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i] <= BASE_RESET;
			end
		end else if (adv) begin
			phase_q     <= phase_d;
			gap_count_q <= gap_count_d;
			scan_q      <= scan_d;
			level_q     <= level_d;
			flag_q      <= flag_n;
			for (int i = 0; i < CHANNELS; i++) begin
				base_q[i] <= base_n[i];
			end
		end
	end

	assign result.start_conv   = start;
	assign result.conv_channel = scan_d[CHAN_OUT_W-1:0];
	assign result.change_irq   = upd & (now != flag_rd);
	assign result.pressed_mask = mask;
	assign result.touch_level  = level_d;

endmodule
